// ----- hdl/jdr_pkg.sv -----
// Shared types and constants of the joystick deadzone reporter.
// No dependencies; every other file of the block imports this package.
package jdr_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int NUM_W       = 2 * SAMPLE_BITS;
   localparam int CHAN_MAX    = 4;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int SEND_W      = 10;
   localparam int DISP_W      = 16;

   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_MIN        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_MAX        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEUTRAL_LEVEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADZONE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_PERIOD    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_PERIOD = 3'd5;

   // reset values of the registers
   localparam logic [SAMPLE_BITS-1:0] RST_RAW_MIN        = 12'd120;
   localparam logic [SAMPLE_BITS-1:0] RST_RAW_MAX        = 12'd3000;
   localparam logic [SAMPLE_BITS-1:0] RST_NEUTRAL_LEVEL  = 12'd2048;
   localparam logic [SAMPLE_BITS-1:0] RST_DEADZONE       = 12'd300;
   localparam logic [SEND_W-1:0]      RST_SEND_PERIOD    = 10'd10;
   localparam logic [DISP_W-1:0]      RST_DISPLAY_PERIOD = 16'd500;

   localparam logic [1:0] MODE_WORK  = 2'd1;
   localparam logic [1:0] MODE_DRIVE = 2'd2;
   localparam logic [1:0] MODE_BTNS_RELEASED = 2'b11;
   localparam logic [1:0] IDLE_SAT = 2'd2;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] raw_min;
      logic [SAMPLE_BITS-1:0] raw_max;
      logic [SAMPLE_BITS-1:0] neutral_level;
      logic [SAMPLE_BITS-1:0] deadzone;
   } scale_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } scale_status_type;

endpackage

// ----- hdl/jdr_divider.sv -----
// Shared restoring divider: one quotient bit per cycle.
// Needs dividend[NUM_W-1:SAMPLE_BITS] < divisor. Depends on jdr_pkg.
module jdr_divider import jdr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start_i,
   input  logic [NUM_W-1:0]       dividend_i,
   input  logic [SAMPLE_BITS-1:0] divisor_i,
   output logic                   done_o,
   output logic [SAMPLE_BITS-1:0] quotient_o
);

   localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] low_ff, low_in;
   logic [SAMPLE_BITS-1:0] quot_ff, quot_in;
   logic [SAMPLE_BITS-1:0] div_ff, div_in;
   logic [SAMPLE_BITS:0]   trial;
   logic                   fits;

   assign trial = {rem_ff, low_ff[SAMPLE_BITS-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quot_in  = quot_ff;
      div_in   = div_ff;
      if (start_i) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(SAMPLE_BITS);
         rem_in   = dividend_i[NUM_W-1:SAMPLE_BITS];
         low_in   = dividend_i[SAMPLE_BITS-1:0];
         div_in   = divisor_i;
      end else if (busy_ff) begin
         rem_in   = fits ? SAMPLE_BITS'(trial - {1'b0, div_ff}) : trial[SAMPLE_BITS-1:0];
         low_in   = {low_ff[SAMPLE_BITS-2:0], 1'b0};
         quot_in  = {quot_ff[SAMPLE_BITS-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      quot_ff  <= quot_in;
      div_ff   <= div_in;
   end

   assign done_o     = done_ff;
   assign quotient_o = quot_ff;

endmodule

// ----- hdl/jdr_scaler.sv -----
// Channel sequencer: clamps each sample, rescales it through the shared
// divider and checks it against the deadzone. Depends on jdr_pkg, jdr_divider.
module jdr_scaler import jdr_pkg::*; #(
   parameter int CHANNELS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start_i,
   input  logic                   take_i,
   input  logic [SAMPLE_BITS-1:0] samples_i [CHAN_MAX],
   input  scale_cfg_type          cfg_i,
   output scale_status_type       status_o,
   output logic [SAMPLE_BITS-1:0] scaled_o [CHANNELS],
   output logic                   active_o
);

   localparam int CHAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SETUP  = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_STORE  = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [CHAN_W-1:0]      chan_ff, chan_in;
   logic                   active_ff, active_in;
   logic [SAMPLE_BITS-1:0] res_ff, res_in;
   logic [SAMPLE_BITS-1:0] samples_ff [CHANNELS];
   logic [SAMPLE_BITS-1:0] scaled_ff [CHANNELS];

   logic [SAMPLE_BITS-1:0] raw;
   logic [SAMPLE_BITS-1:0] offset;
   logic [SAMPLE_BITS-1:0] span;
   logic [NUM_W-1:0]       numerator;
   logic [SAMPLE_BITS-1:0] axis_dist;
   logic                   div_start;
   logic                   div_done;
   logic [SAMPLE_BITS-1:0] quotient;
   logic                   last_chan;

   assign raw       = samples_ff[chan_ff];
   assign offset    = raw - cfg_i.raw_min;
   assign span      = cfg_i.raw_max - cfg_i.raw_min;
   // offset * FULL_SCALE as a shift and subtract
   assign numerator = {offset, {SAMPLE_BITS{1'b0}}} - {{SAMPLE_BITS{1'b0}}, offset};
   assign axis_dist = (res_ff > cfg_i.neutral_level) ? res_ff - cfg_i.neutral_level
                                                     : cfg_i.neutral_level - res_ff;
   assign last_chan = chan_ff == CHAN_W'(CHANNELS - 1);

   jdr_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start_i    (div_start),
      .dividend_i (numerator),
      .divisor_i  (span),
      .done_o     (div_done),
      .quotient_o (quotient)
   );

   always_comb begin
      state_in  = state_ff;
      chan_in   = chan_ff;
      active_in = active_ff;
      res_in    = res_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_i) begin
               chan_in   = '0;
               active_in = 1'b0;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // clamped samples skip the divider
            if (cfg_i.raw_max <= cfg_i.raw_min || raw <= cfg_i.raw_min) begin
               res_in   = '0;
               state_in = ST_STORE;
            end else if (raw >= cfg_i.raw_max) begin
               res_in   = FULL_SCALE;
               state_in = ST_STORE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               res_in   = quotient;
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (axis_dist > cfg_i.deadzone) begin
               active_in = 1'b1;
            end
            if (last_chan) begin
               state_in = ST_DONE;
            end else begin
               chan_in  = chan_ff + 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_DONE: begin
            if (take_i) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      chan_ff   <= chan_in;
      active_ff <= active_in;
      res_ff    <= res_in;
      if (state_ff == ST_IDLE && start_i) begin
         for (int i = 0; i < CHANNELS; i++) begin
            samples_ff[i] <= samples_i[i];
         end
      end
      if (state_ff == ST_STORE) begin
         scaled_ff[chan_ff] <= res_ff;
      end
   end

   assign status_o.busy = state_ff != ST_IDLE;
   assign status_o.done = state_ff == ST_DONE;
   assign scaled_o      = scaled_ff;
   assign active_o      = active_ff;

endmodule

// ----- hdl/joystick_deadzone_reporter.sv -----
// Joystick deadzone reporter, top level. Depends on jdr_pkg, jdr_scaler.
// Holds the csr registers, the per-tick counters and the result register.
//
// One request beat is one tick. The four samples are rescaled one after another
// by a single restoring divider that yields one quotient bit per cycle, and
// clamped channels skip the divider. req_tready stays low from the accepted
// beat until its result has moved into the response register; one finished
// result may wait there while the next tick is being worked on. csr writes take
// effect at once and are meant to be issued only while the block is idle.
module joystick_deadzone_reporter import jdr_pkg::*; #(
   parameter int CHANNELS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // buttons[3:0], adc_ch0[15:4], adc_ch1[27:16], adc_ch2[39:28],
   // adc_ch3[51:40], zero fill [55:52]
   input  logic [55:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // mode[1:0], bucket_down_report[2], bucket_up_report[3], work_pressed[4],
   // drive_pressed[5], joystick_report[6], neutral_report[7],
   // display_refresh[8], scaled_ch0[20:9], scaled_ch1[32:21],
   // scaled_ch2[44:33], scaled_ch3[56:45], zero fill [63:57]
   output logic [63:0]          rsp_tdata,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // csr registers
   logic [SAMPLE_BITS-1:0] raw_min_ff, raw_max_ff, neutral_level_ff, deadzone_ff;
   logic [SEND_W-1:0]      send_period_ff;
   logic [DISP_W-1:0]      display_period_ff;

   // tick state
   logic [1:0]             current_mode_ff, current_mode_in;
   logic [1:0]             last_mode_btns_ff, last_mode_btns_in;
   logic [SEND_W-1:0]      send_count_ff, send_count_in;
   logic [DISP_W-1:0]      display_count_ff, display_count_in;
   logic [1:0]             idle_count_ff, idle_count_in;
   logic [3:0]             buttons_ff;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [63:0]            rsp_data_ff, rsp_data_in;

   scale_cfg_type          scale_cfg;
   scale_status_type       scale_status;
   logic [SAMPLE_BITS-1:0] samples [CHAN_MAX];
   logic [SAMPLE_BITS-1:0] scaled [CHANNELS];
   logic [SAMPLE_BITS-1:0] scaled_out [CHAN_MAX];
   logic                   active;
   logic                   req_accept;
   logic                   load;

   logic                   send_tick;
   logic                   bucket_down, bucket_up, work_pressed, drive_pressed;
   logic                   joy_report, neutral_report, display_refresh;
   logic [1:0]             pressed;
   logic [1:0]             idle_next;
   logic [DISP_W-1:0]      disp_next;
   logic [SEND_W-1:0]      period;
   logic [SEND_W:0]        send_next;

   assign req_tready = !scale_status.busy;
   assign req_accept = req_tvalid && req_tready;
   assign load       = scale_status.done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      for (int i = 0; i < CHAN_MAX; i++) begin
         samples[i] = req_tdata[4 + i*SAMPLE_BITS +: SAMPLE_BITS];
      end
   end

   assign scale_cfg.raw_min       = raw_min_ff;
   assign scale_cfg.raw_max       = raw_max_ff;
   assign scale_cfg.neutral_level = neutral_level_ff;
   assign scale_cfg.deadzone      = deadzone_ff;

   jdr_scaler #(
      .CHANNELS (CHANNELS)
   ) u_scaler (
      .clock     (clock),
      .reset     (reset),
      .start_i   (req_accept),
      .take_i    (load),
      .samples_i (samples),
      .cfg_i     (scale_cfg),
      .status_o  (scale_status),
      .scaled_o  (scaled),
      .active_o  (active)
   );

   // unused channels report zero
   for (genvar g = 0; g < CHAN_MAX; g++) begin : g_out
      if (g < CHANNELS) begin : g_used
         assign scaled_out[g] = scaled[g];
      end else begin : g_unused
         assign scaled_out[g] = '0;
      end
   end

   // tick bookkeeping, applied when the result is loaded
   always_comb begin
      send_tick     = send_count_ff == '0;
      bucket_down   = send_tick && !buttons_ff[0];
      bucket_up     = send_tick && !buttons_ff[3];

      pressed       = last_mode_btns_ff & ~buttons_ff[2:1];
      work_pressed  = pressed[0];
      drive_pressed = pressed[1];
      current_mode_in = current_mode_ff;
      if (drive_pressed) begin
         current_mode_in = MODE_DRIVE;
      end else if (work_pressed) begin
         current_mode_in = MODE_WORK;
      end
      last_mode_btns_in = buttons_ff[2:1];

      idle_next      = (idle_count_ff < IDLE_SAT) ? idle_count_ff + 1'b1 : idle_count_ff;
      joy_report     = send_tick && active;
      neutral_report = send_tick && !active && idle_next == 2'd1;
      idle_count_in  = idle_count_ff;
      if (send_tick) begin
         idle_count_in = active ? 2'd0 : idle_next;
      end

      disp_next        = display_count_ff + 1'b1;
      display_refresh  = disp_next >= display_period_ff;
      display_count_in = display_refresh ? '0 : disp_next;

      period        = (send_period_ff == '0) ? SEND_W'(1) : send_period_ff;
      send_next     = {1'b0, send_count_ff} + 1'b1;
      send_count_in = (send_next >= {1'b0, period}) ? '0 : send_next[SEND_W-1:0];

      rsp_data_in = {7'd0,
                     scaled_out[3], scaled_out[2], scaled_out[1], scaled_out[0],
                     display_refresh, neutral_report, joy_report,
                     drive_pressed, work_pressed, bucket_up, bucket_down,
                     current_mode_in};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_min_ff        <= RST_RAW_MIN;
         raw_max_ff        <= RST_RAW_MAX;
         neutral_level_ff  <= RST_NEUTRAL_LEVEL;
         deadzone_ff       <= RST_DEADZONE;
         send_period_ff    <= RST_SEND_PERIOD;
         display_period_ff <= RST_DISPLAY_PERIOD;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_RAW_MIN:        raw_min_ff        <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_RAW_MAX:        raw_max_ff        <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_NEUTRAL_LEVEL:  neutral_level_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_DEADZONE:       deadzone_ff       <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_SEND_PERIOD:    send_period_ff    <= csr_wdata[SEND_W-1:0];
            CSR_DISPLAY_PERIOD: display_period_ff <= csr_wdata[DISP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_mode_ff   <= MODE_WORK;
         last_mode_btns_ff <= MODE_BTNS_RELEASED;
         send_count_ff     <= '0;
         display_count_ff  <= '0;
         idle_count_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            current_mode_ff   <= current_mode_in;
            last_mode_btns_ff <= last_mode_btns_in;
            send_count_ff     <= send_count_in;
            display_count_ff  <= display_count_in;
            idle_count_ff     <= idle_count_in;
         end
      end
      if (req_accept) begin
         buttons_ff <= req_tdata[3:0];
      end
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request accepted while a tick was still in work");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      current_mode_ff == MODE_WORK || current_mode_ff == MODE_DRIVE)
      else $error("mode left the work and drive codes");

   a_reports_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[6] && rsp_data_ff[7]))
      else $error("joystick and neutral report in one beat");

   a_load_frees_scaler: assert property (@(posedge clock) disable iff (reset)
      load |=> !scale_status.busy)
      else $error("scaler still busy after its result was loaded");
`endif

endmodule
